// File: design/rcfs_pkg.sv
// Shared types and constants for the radio-link failsafe drive mapper.
// No dependencies; used by the mapper, the top level and the testbench.
package rcfs_pkg;

	localparam int unsigned PULSE_W = 11;

	typedef enum logic [1:0] {
		REG_TOP,
		REG_LIMIT,
		REG_WARMUP
	} reg_idx_t;

	typedef enum logic [2:0] {
		MOT_FULL_FWD,
		MOT_FWD,
		MOT_IDLE,
		MOT_REV,
		MOT_FULL_REV
	} mot_cls_t;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse;
		mot_cls_t           cls;
		logic [7:0]         raw;
	} map_t;

	localparam logic [15:0]        CENTER_WORD  = 16'd512;
	localparam logic [PULSE_W-1:0] INIT_PULSE   = 11'd1520;
	localparam logic [15:0]        TOP_RESET    = 16'd19999;
	localparam logic [7:0]         LIMIT_RESET  = 8'd40;
	localparam logic [7:0]         WARMUP_RESET = 8'd4;
	localparam logic [15:0]        SERVO_RESET  = 16'd18479;
	localparam logic [1:0]         TURN_HAZARD  = 2'd3;

endpackage

// File: design/rcfs_pkt_if.sv
// Input channel of the failsafe drive mapper: one packet item per tick.
// Depends on nothing.
interface rcfs_pkt_if;
	logic        valid;
	logic        ready;
	logic        packet_ready;
	logic [15:0] servo_word;
	logic [15:0] motor_word;
	logic [7:0]  signal_byte;

	modport source (output valid, packet_ready, servo_word, motor_word, signal_byte,
		input ready);
	modport sink (input valid, packet_ready, servo_word, motor_word, signal_byte,
		output ready);
endinterface

// File: design/rcfs_drv_if.sv
// Result channel of the failsafe drive mapper: held drive outputs per tick.
// Depends on nothing.
interface rcfs_drv_if;
	logic        valid;
	logic        ready;
	logic [15:0] servo_compare;
	logic [7:0]  motor_a_duty;
	logic [7:0]  motor_b_duty;
	logic [1:0]  turn_code;
	logic        radio_init_req;
	logic        radio_reset_req;
	logic        link_lost;

	modport source (output valid, servo_compare, motor_a_duty, motor_b_duty, turn_code,
		radio_init_req, radio_reset_req, link_lost, input ready);
	modport sink (input valid, servo_compare, motor_a_duty, motor_b_duty, turn_code,
		radio_init_req, radio_reset_req, link_lost, output ready);
endinterface

// File: design/rcfs_map.sv
// Servo and motor word mapping: deadzone, clamp, constant-divisor scaling.
// Depends on rcfs_pkg.
module rcfs_map (
	input  logic [15:0]     servo_word,
	input  logic [15:0]     motor_word,
	output rcfs_pkg::map_t  map
);

	localparam logic [16:0] RECIP_17  = 17'd61681;
	localparam logic [17:0] RECIP_333 = 18'd201529;
	localparam logic [12:0] RECIP_21  = 13'd6242;

	logic [9:0]  p_raw;
	logic [9:0]  p_dz;
	logic [9:0]  p;
	logic [9:0]  x;
	logic [14:0] n_servo;
	logic [31:0] prod_servo;
	logic [9:0]  d_fwd;
	logic [9:0]  d_rev;
	logic [16:0] n_fwd;
	logic [16:0] n_rev;
	logic [34:0] prod_fwd;
	logic [25:0] prod_rev;
	logic [7:0]  q_fwd;
	logic [7:0]  q_rev;

	always_comb begin
		p_raw = servo_word[9:0];
		p_dz  = (p_raw >= 10'd502 && p_raw <= 10'd522) ? 10'd512 : p_raw;
		if (p_dz < 10'd170) begin
			p = 10'd170;
		end else if (p_dz > 10'd850) begin
			p = 10'd850;
		end else begin
			p = p_dz;
		end
		x          = p - 10'd170;
		n_servo    = 15'({x, 5'd0}) - 15'({x, 2'd0});
		prod_servo = 32'(n_servo) * 32'(RECIP_17);
		map.pulse  = 11'(prod_servo[30:20]) + 11'd800;
	end

	always_comb begin
		d_fwd    = 10'd850 - motor_word[9:0];
		d_rev    = 10'd506 - motor_word[9:0];
		n_fwd    = 17'({d_fwd[8:0], 8'd0}) - 17'(d_fwd[8:0]);
		n_rev    = 17'({d_rev[8:0], 8'd0}) - 17'(d_rev[8:0]);
		prod_fwd = 35'(n_fwd) * 35'(RECIP_333);
		prod_rev = 26'(n_rev[16:4]) * 26'(RECIP_21);
		q_fwd    = prod_fwd[33:26];
		q_rev    = prod_rev[24:17];

		if (motor_word > 16'd850) begin
			map.cls = rcfs_pkg::MOT_FULL_FWD;
		end else if (motor_word > 16'd517) begin
			map.cls = rcfs_pkg::MOT_FWD;
		end else if (motor_word > 16'd506) begin
			map.cls = rcfs_pkg::MOT_IDLE;
		end else if (motor_word > 16'd169) begin
			map.cls = rcfs_pkg::MOT_REV;
		end else begin
			map.cls = rcfs_pkg::MOT_FULL_REV;
		end
		map.raw = (map.cls == rcfs_pkg::MOT_FWD) ? q_fwd : 8'd255 - q_rev;
	end

endmodule

// File: design/rc_link_failsafe_drive_mapper.sv
// Registers: input, map and output; an accepted item passes through them in that order.
// Throughput: one item per cycle unless stalled; the link state updates once per item in the map stage.
// Input is stalled only while all three stages are full and the result is not taken.
// Reset: asynchronous, active low; link mode init, counts zero, holds at center/brake values,
// configuration at its defaults. No clearing pass.
// Depends on rcfs_pkg, rcfs_pkt_if, rcfs_drv_if and rcfs_map.
module rc_link_failsafe_drive_mapper (
	input  logic              clk,
	input  logic              arst_n,
	rcfs_pkt_if.sink          pkt,
	rcfs_drv_if.source        drive,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	typedef enum logic [1:0] {
		MODE_INIT,
		MODE_READ,
		MODE_LOST
	} mode_t;

	localparam logic [16:0] RECIP_255 = 17'd16449;

	logic [15:0] top_q;
	logic [7:0]  limit_q;
	logic [7:0]  warmup_q;

	mode_t       mode_q;
	mode_t       mode_nx;
	logic [7:0]  drop_q;
	logic [7:0]  drop_nx;
	logic [7:0]  drop_inc;
	logic [7:0]  warm_q;
	logic [7:0]  warm_nx;

	logic        v1_q;
	logic        v2_q;
	logic        vout_q;
	logic        adv2;
	logic        adv3;

	logic        ready_s1;
	logic [15:0] servo_s1;
	logic [15:0] motor_s1;
	logic [1:0]  turn_s1;

	logic        init_c;
	logic        rreq_c;
	logic        apply_c;
	logic        fail_c;
	logic [15:0] servo_in;
	logic [15:0] motor_in;
	rcfs_pkg::map_t map;

	logic        init_s2;
	logic        rreq_s2;
	logic        lost_s2;
	logic        upd_servo_s2;
	logic        upd_motor_s2;
	logic        upd_turn_s2;
	logic [rcfs_pkg::PULSE_W-1:0] pulse_s2;
	rcfs_pkg::mot_cls_t cls_s2;
	logic [7:0]  raw_s2;
	logic [1:0]  turn_s2;

	logic [13:0] n_duty;
	logic [30:0] prod_duty;
	logic [7:0]  duty;
	logic [7:0]  duty_a;
	logic [7:0]  duty_b;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= rcfs_pkg::TOP_RESET;
			limit_q  <= rcfs_pkg::LIMIT_RESET;
			warmup_q <= rcfs_pkg::WARMUP_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				rcfs_pkg::REG_TOP:    top_q    <= pwdata[15:0];
				rcfs_pkg::REG_LIMIT:  limit_q  <= pwdata[7:0];
				rcfs_pkg::REG_WARMUP: warmup_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			rcfs_pkg::REG_TOP:    prdata = 32'(top_q);
			rcfs_pkg::REG_LIMIT:  prdata = 32'(limit_q);
			rcfs_pkg::REG_WARMUP: prdata = 32'(warmup_q);
			default:              prdata = 32'd0;
		endcase
	end

	assign adv3      = v2_q && (!vout_q || drive.ready);
	assign adv2      = v1_q && (!v2_q || adv3);
	assign pkt.ready = !v1_q || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (pkt.ready) begin
			v1_q <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			ready_s1 <= pkt.packet_ready;
			servo_s1 <= pkt.servo_word;
			motor_s1 <= pkt.motor_word;
			turn_s1  <= pkt.signal_byte[1:0];
		end
	end

	always_comb begin
		mode_nx  = mode_q;
		drop_nx  = drop_q;
		warm_nx  = warm_q;
		drop_inc = drop_q + 8'd1;
		init_c   = 1'b0;
		rreq_c   = 1'b0;
		apply_c  = 1'b0;
		fail_c   = 1'b0;
		unique case (mode_q)
			MODE_INIT: begin
				drop_nx = 8'd0;
				warm_nx = 8'd0;
				init_c  = 1'b1;
				mode_nx = MODE_READ;
			end
			MODE_READ, MODE_LOST: begin
				if (ready_s1) begin
					drop_nx = 8'd0;
					if (warm_q == warmup_q) begin
						apply_c = 1'b1;
						mode_nx = MODE_READ;
					end else begin
						warm_nx = warm_q + 8'd1;
					end
				end else if (drop_inc == limit_q) begin
					drop_nx = 8'd0;
					if (mode_q == MODE_READ) begin
						fail_c  = 1'b1;
						warm_nx = 8'd0;
						mode_nx = MODE_LOST;
					end else begin
						rreq_c = 1'b1;
					end
				end else begin
					drop_nx = drop_inc;
				end
			end
			default: mode_nx = MODE_INIT;
		endcase
	end

	assign servo_in = fail_c ? rcfs_pkg::CENTER_WORD : servo_s1;
	assign motor_in = fail_c ? rcfs_pkg::CENTER_WORD : motor_s1;

	rcfs_map u_map (
		.servo_word (servo_in),
		.motor_word (motor_in),
		.map        (map)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_INIT;
			drop_q <= 8'd0;
			warm_q <= 8'd0;
			v2_q   <= 1'b0;
		end else begin
			if (adv2) begin
				mode_q <= mode_nx;
				drop_q <= drop_nx;
				warm_q <= warm_nx;
			end
			if (adv2) begin
				v2_q <= 1'b1;
			end else if (adv3) begin
				v2_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			init_s2      <= init_c;
			rreq_s2      <= rreq_c;
			lost_s2      <= (mode_nx == MODE_LOST);
			upd_servo_s2 <= init_c || apply_c || fail_c;
			upd_motor_s2 <= init_c || apply_c || fail_c;
			upd_turn_s2  <= apply_c || fail_c;
			pulse_s2     <= init_c ? rcfs_pkg::INIT_PULSE : map.pulse;
			cls_s2       <= init_c ? rcfs_pkg::MOT_IDLE : map.cls;
			raw_s2       <= map.raw;
			turn_s2      <= fail_c ? rcfs_pkg::TURN_HAZARD : turn_s1;
		end
	end

	always_comb begin
		n_duty    = 14'({raw_s2, 5'd0}) + 14'({raw_s2, 4'd0}) + 14'({raw_s2, 1'd0});
		prod_duty = 31'(n_duty) * 31'(RECIP_255);
		duty      = 8'(prod_duty[27:22]) + 8'd175;
		unique case (cls_s2)
			rcfs_pkg::MOT_FULL_FWD: begin
				duty_a = 8'd255;
				duty_b = 8'd0;
			end
			rcfs_pkg::MOT_FWD: begin
				duty_a = 8'd255;
				duty_b = duty;
			end
			rcfs_pkg::MOT_REV: begin
				duty_a = duty;
				duty_b = 8'd255;
			end
			rcfs_pkg::MOT_FULL_REV: begin
				duty_a = 8'd0;
				duty_b = 8'd255;
			end
			default: begin
				duty_a = 8'd255;
				duty_b = 8'd255;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout_q                <= 1'b0;
			drive.servo_compare   <= rcfs_pkg::SERVO_RESET;
			drive.motor_a_duty    <= 8'd255;
			drive.motor_b_duty    <= 8'd255;
			drive.turn_code       <= 2'd0;
			drive.radio_init_req  <= 1'b0;
			drive.radio_reset_req <= 1'b0;
			drive.link_lost       <= 1'b0;
		end else begin
			if (adv3) begin
				vout_q <= 1'b1;
			end else if (drive.ready) begin
				vout_q <= 1'b0;
			end
			if (adv3) begin
				if (upd_servo_s2) begin
					drive.servo_compare <= top_q - 16'(pulse_s2);
				end
				if (upd_motor_s2) begin
					drive.motor_a_duty <= duty_a;
					drive.motor_b_duty <= duty_b;
				end
				if (upd_turn_s2) begin
					drive.turn_code <= turn_s2;
				end
				drive.radio_init_req  <= init_s2;
				drive.radio_reset_req <= rreq_s2;
				drive.link_lost       <= lost_s2;
			end
		end
	end

	assign drive.valid = vout_q;

	a_req_excl: assert property (@(posedge clk) disable iff (!arst_n)
		vout_q |-> !(drive.radio_init_req && drive.radio_reset_req))
		else $error("init and reset requests in one item");

	a_init_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		vout_q && drive.radio_init_req |-> !drive.link_lost)
		else $error("init item reports lost link");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pkt.ready |-> v1_q && v2_q && vout_q && !drive.ready)
		else $error("input stalled with a free stage");

	a_adv_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv2 |=> v2_q)
		else $error("advanced item lost in map stage");

endmodule

// File: tb/sv/rc_link_failsafe_drive_mapper_tb.sv
// Testbench for rc_link_failsafe_drive_mapper: random and directed ticks with a
// cycle-free link/drive predictor and an in-order scoreboard of drive results.
// Depends on rcfs_pkg, rcfs_pkt_if, rcfs_drv_if and the mapper RTL.
module rc_link_failsafe_drive_mapper_tb;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned STALL_LEN   = 80;
	localparam int unsigned ITEM_TARGET = 1350;

	typedef enum logic [1:0] {
		LINK_INIT,
		LINK_READ,
		LINK_LOST,
		LINK_SPARE
	} link_mode_t;

	typedef struct packed {
		logic        packet_ready;
		logic [15:0] servo_word;
		logic [15:0] motor_word;
		logic [7:0]  signal_byte;
	} tick_t;

	typedef struct packed {
		logic [15:0] servo_compare;
		logic [7:0]  motor_a_duty;
		logic [7:0]  motor_b_duty;
		logic [1:0]  turn_code;
		logic        radio_init_req;
		logic        radio_reset_req;
		logic        link_lost;
	} drive_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic  src_valid = 1'b0;
	tick_t src_tick = '0;
	logic  snk_ready = 1'b0;

	rcfs_pkt_if pkt_ch ();
	rcfs_drv_if drv_ch ();

	assign pkt_ch.valid        = src_valid;
	assign pkt_ch.packet_ready = src_tick.packet_ready;
	assign pkt_ch.servo_word   = src_tick.servo_word;
	assign pkt_ch.motor_word   = src_tick.motor_word;
	assign pkt_ch.signal_byte  = src_tick.signal_byte;
	assign drv_ch.ready        = snk_ready;

	rc_link_failsafe_drive_mapper i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (pkt_ch),
		.drive   (drv_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial forever #5 clk = ~clk;

	tick_t       tick_q [$];
	drive_t      drive_q [$];
	int unsigned ticks_queued = 0;
	int unsigned n_results = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	logic        pkt_taken = 1'b0;
	logic        drv_taken = 1'b0;

	int unsigned servo_corners [13] = '{0, 169, 170, 171, 501, 502, 512, 522, 523, 849, 850,
		851, 1023};
	int unsigned motor_corners [14] = '{0, 169, 170, 171, 505, 506, 507, 508, 516, 517, 518,
		849, 850, 851};

	// link predictor state and its copy of the configuration
	logic [15:0] cfg_top = rcfs_pkg::TOP_RESET;
	logic [7:0]  cfg_limit = rcfs_pkg::LIMIT_RESET;
	logic [7:0]  cfg_warm = rcfs_pkg::WARMUP_RESET;
	link_mode_t  mode = LINK_INIT;
	logic [7:0]  drops = '0;
	logic [7:0]  warm_cnt = '0;
	logic [15:0] hold_servo = rcfs_pkg::SERVO_RESET;
	logic [7:0]  hold_a = 8'hFF;
	logic [7:0]  hold_b = 8'hFF;
	logic [1:0]  hold_turn = '0;

	function automatic logic [15:0] servo_compare_for(input logic [15:0] word);
		int unsigned pos, pulse;
		pos = word & 16'h03FF;
		if (pos >= 502 && pos <= 522) pos = 512;
		if (pos < 170) pos = 170;
		if (pos > 850) pos = 850;
		pulse = ((pos - 170) * 1400) / 850 + 800;
		return cfg_top - pulse[15:0];
	endfunction

	function automatic logic [7:0] bridge_duty(input int unsigned d);
		return 8'((d * 50) / 255 + 175);
	endfunction

	function automatic void drive_motor(input logic [15:0] speed);
		int unsigned s;
		s = speed;
		if (s > 850) begin
			hold_a = 8'hFF;
			hold_b = 8'h00;
		end else if (s > 517) begin
			hold_a = 8'hFF;
			hold_b = bridge_duty(((850 - s) * 255) / 333);
		end else if (s > 506) begin
			hold_a = 8'hFF;
			hold_b = 8'hFF;
		end else if (s > 169) begin
			hold_a = bridge_duty(255 - ((506 - s) * 255) / 336);
			hold_b = 8'hFF;
		end else begin
			hold_a = 8'h00;
			hold_b = 8'hFF;
		end
	endfunction

	function automatic drive_t advance_link(input tick_t t);
		logic init_req, reset_req;
		init_req = 1'b0;
		reset_req = 1'b0;
		case (mode)
			LINK_INIT: begin
				drops = '0;
				warm_cnt = '0;
				hold_a = 8'hFF;
				hold_b = 8'hFF;
				hold_servo = cfg_top - 16'(rcfs_pkg::INIT_PULSE);
				init_req = 1'b1;
				mode = LINK_READ;
			end
			LINK_READ, LINK_LOST: begin
				if (t.packet_ready) begin
					drops = '0;
					if (warm_cnt == cfg_warm) begin
						hold_servo = servo_compare_for(t.servo_word);
						drive_motor(t.motor_word);
						hold_turn = t.signal_byte[1:0];
						mode = LINK_READ;
					end else begin
						warm_cnt = warm_cnt + 8'd1;
					end
				end else begin
					drops = drops + 8'd1;
					if (drops == cfg_limit) begin
						drops = '0;
						if (mode == LINK_READ) begin
							drive_motor(rcfs_pkg::CENTER_WORD);
							hold_servo = servo_compare_for(rcfs_pkg::CENTER_WORD);
							hold_turn = rcfs_pkg::TURN_HAZARD;
							warm_cnt = '0;
							mode = LINK_LOST;
						end else begin
							reset_req = 1'b1;
						end
					end
				end
			end
			default: mode = LINK_INIT;
		endcase
		return '{hold_servo, hold_a, hold_b, hold_turn, init_req, reset_req, mode == LINK_LOST};
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		drive_t got, want;
		pkt_taken = arst_n && pkt_ch.valid && pkt_ch.ready;
		drv_taken = arst_n && drv_ch.valid && drv_ch.ready;
		if (pkt_taken) drive_q.push_back(advance_link(src_tick));
		if (drv_taken) begin
			got = '{drv_ch.servo_compare, drv_ch.motor_a_duty, drv_ch.motor_b_duty,
				drv_ch.turn_code, drv_ch.radio_init_req, drv_ch.radio_reset_req,
				drv_ch.link_lost};
			n_results++;
			if (drive_q.size() == 0) begin
				$error("unexpected result: servo_compare %0d", got.servo_compare);
				mismatches++;
			end else begin
				want = drive_q.pop_front();
				check_field("servo_compare", want.servo_compare, got.servo_compare);
				check_field("motor_a_duty", want.motor_a_duty, got.motor_a_duty);
				check_field("motor_b_duty", want.motor_b_duty, got.motor_b_duty);
				check_field("turn_code", want.turn_code, got.turn_code);
				check_field("radio_init_req", want.radio_init_req, got.radio_init_req);
				check_field("radio_reset_req", want.radio_reset_req, got.radio_reset_req);
				check_field("link_lost", want.link_lost, got.link_lost);
			end
		end
	end

	int unsigned src_wait = 0;
	logic        src_calm = 1'b0;

	always @(negedge clk) begin
		if (arst_n && (!src_valid || pkt_taken)) begin
			if (src_wait != 0) begin
				src_wait--;
				src_valid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				src_tick <= tick_q.pop_front();
				src_valid <= 1'b1;
				if ($urandom_range(0, 15) == 0) src_calm = !src_calm;
				src_wait = src_calm ? 0 : $urandom_range(0, 4);
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	int unsigned snk_wait = 0;
	int unsigned stall_left = 0;
	int unsigned next_stall = 200;
	logic        snk_calm = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (drv_taken) begin
				if ($urandom_range(0, 15) == 0) snk_calm = !snk_calm;
				snk_wait = snk_calm ? 0 : $urandom_range(0, 4);
			end
			if (n_results >= next_stall) begin
				stall_left = STALL_LEN;
				next_stall += 500;
			end
			if (stall_left != 0) begin
				stall_left--;
				snk_ready <= 1'b0;
			end else if (snk_wait != 0) begin
				snk_wait--;
				snk_ready <= 1'b0;
			end else begin
				snk_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((pkt_ch.valid && pkt_ch.ready) || (drv_ch.valid && drv_ch.ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic set_reg(input rcfs_pkg::reg_idx_t idx, input logic [31:0] value);
		logic [31:0] want, got;
		case (idx)
			rcfs_pkg::REG_TOP: begin
				cfg_top = value[15:0];
				want = {16'd0, value[15:0]};
			end
			rcfs_pkg::REG_LIMIT: begin
				cfg_limit = value[7:0];
				want = {24'd0, value[7:0]};
			end
			default: begin
				cfg_warm = value[7:0];
				want = {24'd0, value[7:0]};
			end
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		check_field(idx.name(), want, got);
	endtask

	task automatic configure(input logic [15:0] top, input logic [7:0] limit,
		input logic [7:0] warm);
		set_reg(rcfs_pkg::REG_TOP, {16'd0, top});
		set_reg(rcfs_pkg::REG_LIMIT, {24'd0, limit});
		set_reg(rcfs_pkg::REG_WARMUP, {24'd0, warm});
	endtask

	task automatic settle();
		while (tick_q.size() != 0 || src_valid || drive_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic void add_tick(input logic rdy, input logic [15:0] servo,
		input logic [15:0] motor, input logic [7:0] sig);
		tick_q.push_back('{rdy, servo, motor, sig});
		ticks_queued++;
	endfunction

	function automatic logic [15:0] pick_servo_word();
		logic [15:0] w;
		w = 16'($urandom);
		case ($urandom_range(0, 2))
			0: w[9:0] = 10'(servo_corners[$urandom_range(0, 12)]);
			1: w = 16'($urandom_range(0, 1023));
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic [15:0] pick_motor_word();
		case ($urandom_range(0, 3))
			0, 1: return 16'(motor_corners[$urandom_range(0, 13)]);
			2: return 16'($urandom_range(0, 1023));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_packet();
		add_tick(1'b1, pick_servo_word(), pick_motor_word(), 8'($urandom));
	endfunction

	function automatic void add_drop();
		add_tick(1'b0, 16'($urandom), 16'($urandom), 8'($urandom));
	endfunction

	function automatic void add_link_traffic(input int unsigned n);
		int unsigned stop, run, span;
		stop = ticks_queued + n;
		span = (cfg_limit == 0) ? 256 : cfg_limit;
		while (ticks_queued < stop) begin
			if ($urandom_range(0, 9) < 6) begin
				run = $urandom_range(1, 8);
				repeat (run) add_packet();
			end else begin
				case ($urandom_range(0, 4))
					0: run = span - 1;
					1: run = span;
					2: run = 2 * span;
					3: run = $urandom_range(1, 3);
					default: run = span + $urandom_range(1, span);
				endcase
				repeat (run) add_drop();
			end
		end
	endfunction

	initial begin
		logic [15:0] top;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		configure(16'd1000, 8'd2, 8'd1);
		add_tick(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
		add_tick(1'b1, 16'd512, 16'd512, 8'h00);
		add_tick(1'b1, 16'h0000, 16'h0000, 8'h00);
		add_tick(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
		add_tick(1'b1, 16'd501, 16'd169, 8'h01);
		add_tick(1'b1, 16'd502, 16'd170, 8'h02);
		add_tick(1'b1, 16'd522, 16'd506, 8'h03);
		add_tick(1'b1, 16'd523, 16'd507, 8'h00);
		add_tick(1'b1, 16'd169, 16'd517, 8'h55);
		add_tick(1'b1, 16'd170, 16'd518, 8'hAA);
		add_tick(1'b1, 16'd850, 16'd850, 8'hFE);
		add_tick(1'b1, 16'd851, 16'd851, 8'h01);
		add_tick(1'b1, 16'hFE00, 16'h0400, 8'h03);
		add_tick(1'b1, 16'd1023, 16'h8000, 8'h02);
		repeat (5) add_drop();
		add_tick(1'b1, 16'd300, 16'd300, 8'h01);
		add_tick(1'b1, 16'd700, 16'd700, 8'h02);
		settle();

		// long warm-up; leaves the count at its top for the wrap below
		configure(16'hFFFF, 8'd255, 8'd255);
		repeat (258) add_packet();
		settle();

		configure(16'd2200, 8'd1, 8'd3);
		add_link_traffic(40);
		settle();

		configure(rcfs_pkg::TOP_RESET, 8'd0, 8'd0);
		repeat (5) add_packet();
		repeat (256) add_drop();
		repeat (2) add_packet();
		settle();

		while (ticks_queued < ITEM_TARGET) begin
			case ($urandom_range(0, 3))
				0: top = 16'd2200;
				1: top = 16'hFFFF;
				2: top = 16'($urandom_range(2200, 65535));
				default: top = 16'($urandom_range(0, 2199));
			endcase
			configure(top, 8'($urandom_range(1, 12)),
				8'(($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3)));
			add_link_traffic(100);
			settle();
		end

		if (mismatches == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
